[sv/pli_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the positional list engine.
// No dependencies.
package pli_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    localparam int POS_W = 5;
    localparam int DATA_W = 32;
    localparam int COUNT_W = 5;

    // Broadcast command to every cell of the row
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

[sv/pli_cell.sv]
`timescale 1ns / 1ps
// One list slot: holds a single entry and shifts with its neighbors.
// Depends on pli_pkg.
module pli_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                        clk,
    input  pli_pkg::cell_ctrl_t         ctrl,
    input  logic [CW-1:0]               cnt,
    input  logic [pli_pkg::DATA_W-1:0]  left,
    input  logic [pli_pkg::DATA_W-1:0]  right,
    output logic [pli_pkg::DATA_W-1:0]  data
);

    localparam int MW = ((CW > pli_pkg::POS_W) ? CW : pli_pkg::POS_W) + 2;
    localparam logic [MW-1:0] K1 = MW'(IDX + 1);

    logic [pli_pkg::DATA_W-1:0] data_reg;
    logic [pli_pkg::DATA_W-1:0] data_next;
    logic [MW-1:0]              pe;
    logic [MW-1:0]              ce;

    assign pe = MW'(ctrl.pos);
    assign ce = MW'(cnt);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins)
        begin
            if (K1 == pe)
                data_next = ctrl.value;
            else if (K1 > pe && K1 <= ce + MW'(1))
                data_next = left;
        end
        else if (ctrl.del)
        begin
            if (K1 >= pe && K1 < ce)
                data_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[sv/positional_list_insert_delete.sv]
`timescale 1ns / 1ps
// Top level of the positional list engine: row of pli_cell slots plus count and result register.
// Depends on pli_pkg and pli_cell.
//
// Holds an ordered list of up to CAPACITY signed 32-bit entries. Each request (insert, delete
// or read at a 1-based position) is taken and its result appears in the output
// register on the next cycle; a new request is taken every cycle as long as results are drained.
// Insert and delete move every affected slot at once, each slot loading from its left or right
// neighbor, so the throughput is one request per cycle at any CAPACITY unless the output stalls.
// The count output is the entry count modulo 32.
module positional_list_insert_delete #(
    parameter int CAPACITY = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          operation,
    input  logic [pli_pkg::POS_W-1:0]           position,
    input  logic signed [pli_pkg::DATA_W-1:0]   value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic [pli_pkg::COUNT_W-1:0]         count,
    output logic signed [pli_pkg::DATA_W-1:0]   read_value
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int MW  = ((CW > pli_pkg::POS_W) ? CW : pli_pkg::POS_W) + 2;
    localparam int RDN = (CAPACITY < 31) ? CAPACITY : 31;

    logic [pli_pkg::DATA_W-1:0] entries [CAPACITY];
    pli_pkg::cell_ctrl_t        ctrl;

    logic [CW-1:0]                 cnt_reg;
    logic [CW-1:0]                 cnt_next;
    logic [MW-1:0]                 cnt_ext;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    pli_pkg::status_t              status_reg;
    pli_pkg::status_t              status_next;
    logic [pli_pkg::COUNT_W-1:0]   count_reg;
    logic [pli_pkg::COUNT_W-1:0]   count_next;
    logic [pli_pkg::DATA_W-1:0]    rdata_reg;
    logic [pli_pkg::DATA_W-1:0]    rdata_next;

    logic          accept;
    logic [MW-1:0] pe;
    logic [MW-1:0] ce;
    logic          pos_nz;
    logic          ins_pos_ok;
    logic          pos_in_list;
    logic          is_full;
    logic          ins_ok;
    logic          del_ok;
    logic [pli_pkg::DATA_W-1:0] rd_mux;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign pe          = MW'(position);
    assign ce          = MW'(cnt_reg);
    assign pos_nz      = (position != '0);
    assign ins_pos_ok  = pos_nz && (pe <= ce + MW'(1));
    assign pos_in_list = pos_nz && (pe <= ce);
    assign is_full     = (ce == MW'(CAPACITY));
    assign ins_ok      = (operation == pli_pkg::OP_INSERT) && ins_pos_ok && !is_full;
    assign del_ok      = (operation == pli_pkg::OP_DELETE) && pos_in_list;

    assign ctrl.ins   = accept && ins_ok;
    assign ctrl.del   = accept && del_ok;
    assign ctrl.pos   = position;
    assign ctrl.value = value;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [pli_pkg::DATA_W-1:0] left_d;
            logic [pli_pkg::DATA_W-1:0] right_d;
            if (g == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_mid_l
                assign left_d = entries[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_mid_r
                assign right_d = entries[g+1];
            end
            pli_cell #(
                .IDX (g),
                .CW  (CW)
            ) u_cell (
                .clk   (clk),
                .ctrl  (ctrl),
                .cnt   (cnt_reg),
                .left  (left_d),
                .right (right_d),
                .data  (entries[g])
            );
        end
    endgenerate

    always_comb
    begin
        rd_mux = '0;
        for (int k = 0; k < RDN; k++)
        begin
            if (pli_pkg::POS_W'(k + 1) == position)
                rd_mux = entries[k];
        end
    end

    always_comb
    begin
        cnt_next    = cnt_reg;
        status_next = pli_pkg::ST_BADPOS;
        rdata_next  = '0;
        unique case (operation)
            pli_pkg::OP_INSERT:
            begin
                if (ins_pos_ok && is_full)
                    status_next = pli_pkg::ST_FULL;
                else if (ins_ok)
                begin
                    status_next = pli_pkg::ST_OK;
                    cnt_next    = cnt_reg + CW'(1);
                end
            end
            pli_pkg::OP_DELETE:
            begin
                if (del_ok)
                begin
                    status_next = pli_pkg::ST_OK;
                    cnt_next    = cnt_reg - CW'(1);
                end
            end
            pli_pkg::OP_READ:
            begin
                if (pos_in_list)
                begin
                    status_next = pli_pkg::ST_OK;
                    rdata_next  = rd_mux;
                end
            end
            default:
            begin
                status_next = pli_pkg::ST_BADPOS;
            end
        endcase
        cnt_ext        = MW'(cnt_next);
        count_next     = cnt_ext[pli_pkg::COUNT_W-1:0];
        out_valid_next = accept || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
                cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            count_reg  <= count_next;
            rdata_reg  <= rdata_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign count      = count_reg;
    assign read_value = rdata_reg;

endmodule

[sv/pli_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the positional list engine, bound to the top level.
// Depends on pli_pkg and positional_list_insert_delete.
module pli_checker #(
    parameter int CAPACITY = 16
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic [1:0]                          operation,
    input logic [pli_pkg::POS_W-1:0]           position,
    input logic signed [pli_pkg::DATA_W-1:0]   value,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [1:0]                          status,
    input logic [pli_pkg::COUNT_W-1:0]         count,
    input logic signed [pli_pkg::DATA_W-1:0]   read_value
);

    localparam logic [pli_pkg::COUNT_W-1:0] CAP_MOD = pli_pkg::COUNT_W'(CAPACITY);

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == pli_pkg::ST_FULL |-> count == CAP_MOD)
        else $error("full status with count not at capacity");

    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != pli_pkg::ST_OK |-> read_value == '0)
        else $error("nonzero read data on failed request");

    a_bad_op: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && operation != pli_pkg::OP_INSERT
        && operation != pli_pkg::OP_DELETE && operation != pli_pkg::OP_READ
        |=> out_valid && status == pli_pkg::ST_BADPOS)
        else $error("unused operation not rejected");

    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && position == '0
        |=> out_valid && status == pli_pkg::ST_BADPOS)
        else $error("position zero not rejected");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count)
        && $stable(read_value))
        else $error("result changed while stalled");

endmodule

bind positional_list_insert_delete pli_checker #(.CAPACITY(CAPACITY)) u_pli_checker (.*);
